[hw/rtl/csl_pkg.sv]
// ----------------------------------------------------------------------------
// csl_pkg
// Shared types, token codes and character helpers for the C subset lexer.
// ----------------------------------------------------------------------------
package csl_pkg;

    localparam int unsigned DEF_LINE_BITS     = 20;
    localparam int unsigned DEF_POSITION_BITS = 32;
    localparam int unsigned DEF_LENGTH_BITS   = 16;

    localparam int unsigned KIND_W = 5;
    localparam int unsigned ERR_W  = 3;

    // Lexer modes, one-hot
    typedef enum logic [12:0] {
        M_IDLE       = 13'b0000000000001,
        M_IDENT      = 13'b0000000000010,
        M_NUMBER     = 13'b0000000000100,
        M_SLASH      = 13'b0000000001000,
        M_ASSIGN     = 13'b0000000010000,
        M_COMMENT    = 13'b0000000100000,
        M_STRING     = 13'b0000001000000,
        M_STRING_ESC = 13'b0000010000000,
        M_CHAR_OPEN  = 13'b0000100000000,
        M_CHAR_ESC   = 13'b0001000000000,
        M_CHAR_CLOSE = 13'b0010000000000,
        M_CHAR_SKIP  = 13'b0100000000000,
        M_SKIP_LINE  = 13'b1000000000000
    } mode_t;

    // Token kinds
    localparam logic [KIND_W-1:0] K_VOID   = 5'd0;
    localparam logic [KIND_W-1:0] K_CHARKW = 5'd1;
    localparam logic [KIND_W-1:0] K_INTKW  = 5'd2;
    localparam logic [KIND_W-1:0] K_IF     = 5'd3;
    localparam logic [KIND_W-1:0] K_ELSE   = 5'd4;
    localparam logic [KIND_W-1:0] K_WHILE  = 5'd5;
    localparam logic [KIND_W-1:0] K_FOR    = 5'd6;
    localparam logic [KIND_W-1:0] K_MAIN   = 5'd7;
    localparam logic [KIND_W-1:0] K_IDENT  = 5'd8;
    localparam logic [KIND_W-1:0] K_INT    = 5'd9;
    localparam logic [KIND_W-1:0] K_STRING = 5'd10;
    localparam logic [KIND_W-1:0] K_CHAR   = 5'd11;
    localparam logic [KIND_W-1:0] K_ASSIGN = 5'd12;
    localparam logic [KIND_W-1:0] K_EQ     = 5'd13;
    localparam logic [KIND_W-1:0] K_PLUS   = 5'd14;
    localparam logic [KIND_W-1:0] K_MINUS  = 5'd15;
    localparam logic [KIND_W-1:0] K_STAR   = 5'd16;
    localparam logic [KIND_W-1:0] K_SLASH  = 5'd17;
    localparam logic [KIND_W-1:0] K_GT     = 5'd18;
    localparam logic [KIND_W-1:0] K_LT     = 5'd19;
    localparam logic [KIND_W-1:0] K_LPAREN = 5'd20;
    localparam logic [KIND_W-1:0] K_RPAREN = 5'd21;
    localparam logic [KIND_W-1:0] K_LBRACE = 5'd22;
    localparam logic [KIND_W-1:0] K_RBRACE = 5'd23;
    localparam logic [KIND_W-1:0] K_LBRACK = 5'd24;
    localparam logic [KIND_W-1:0] K_RBRACK = 5'd25;
    localparam logic [KIND_W-1:0] K_SEMI   = 5'd26;
    localparam logic [KIND_W-1:0] K_COMMA  = 5'd27;

    // Error codes
    localparam logic [ERR_W-1:0] E_NONE    = 3'd0;
    localparam logic [ERR_W-1:0] E_UNDEF   = 3'd1;
    localparam logic [ERR_W-1:0] E_COMMENT = 3'd2;
    localparam logic [ERR_W-1:0] E_STRING  = 3'd3;
    localparam logic [ERR_W-1:0] E_CHAR    = 3'd4;

    // Character codes
    localparam logic [7:0] CH_NL    = 8'h0A;
    localparam logic [7:0] CH_DQ    = 8'h22;
    localparam logic [7:0] CH_SQ    = 8'h27;
    localparam logic [7:0] CH_BSL   = 8'h5C;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_EQ    = 8'h3D;
    localparam logic [7:0] CH_UNDER = 8'h5F;

    function automatic logic is_lower(input logic [7:0] b);
        return (b >= 8'h61) && (b <= 8'h7A);
    endfunction

    function automatic logic is_alpha(input logic [7:0] b);
        return is_lower(b) || ((b >= 8'h41) && (b <= 8'h5A));
    endfunction

    function automatic logic is_digit(input logic [7:0] b);
        return (b >= 8'h30) && (b <= 8'h39);
    endfunction

    function automatic logic is_space(input logic [7:0] b);
        return (b == 8'h20) || (b == CH_NL) || ((b >= 8'h09) && (b <= 8'h0D));
    endfunction

    // Uppercase a letter
    function automatic logic [7:0] to_upper(input logic [7:0] b);
        return is_lower(b) ? (b - 8'd32) : b;
    endfunction

    // Keyword lookup on the packed uppercase letters
    function automatic logic [KIND_W-1:0] word_kind(input logic [39:0] kw, input logic short);
        logic [KIND_W-1:0] k;
        k = K_IDENT;
        if (short)
        begin
            case (kw)
                40'h00564F4944: k = K_VOID;
                40'h0043484152: k = K_CHARKW;
                40'h0000494E54: k = K_INTKW;
                40'h0000004946: k = K_IF;
                40'h00454C5345: k = K_ELSE;
                40'h5748494C45: k = K_WHILE;
                40'h0000464F52: k = K_FOR;
                40'h004D41494E: k = K_MAIN;
                default:        k = K_IDENT;
            endcase
        end
        return k;
    endfunction

    // One-character operators: valid flag and kind
    function automatic logic [KIND_W:0] op_kind(input logic [7:0] b);
        logic [KIND_W:0] r;
        case (b)
            8'h2B:   r = {1'b1, K_PLUS};
            8'h2D:   r = {1'b1, K_MINUS};
            8'h2A:   r = {1'b1, K_STAR};
            8'h3E:   r = {1'b1, K_GT};
            8'h3C:   r = {1'b1, K_LT};
            8'h28:   r = {1'b1, K_LPAREN};
            8'h29:   r = {1'b1, K_RPAREN};
            8'h7B:   r = {1'b1, K_LBRACE};
            8'h7D:   r = {1'b1, K_RBRACE};
            8'h5B:   r = {1'b1, K_LBRACK};
            8'h5D:   r = {1'b1, K_RBRACK};
            8'h3B:   r = {1'b1, K_SEMI};
            8'h2C:   r = {1'b1, K_COMMA};
            default: r = {1'b0, K_IDENT};
        endcase
        return r;
    endfunction

endpackage

[hw/rtl/c_subset_lexer.sv]
// ----------------------------------------------------------------------------
// c_subset_lexer
// Byte-serial lexer for a small C subset with a four-entry result queue.
// ----------------------------------------------------------------------------
// Usage:
//   Slave channel s_*: one source byte per transfer in s_tdata[7:0]; a transfer
//   with s_tlast high marks end of input (its byte is ignored), flushes any
//   pending token or open-construct error, and returns the lexer to its reset
//   state so the next byte starts a new source.
//   Master channel m_*: one token or error per transfer; m_tlast is high on the
//   last result caused by one input transfer.
//   Throughput: one byte per cycle while s_tready is high. Each byte updates
//   the lexer state in the cycle it is accepted, using one level of mode decode
//   and the keyword compare, and pushes zero, one or two results into the queue.
//   Results enter the queue registers when the completing byte is accepted;
//   words, numbers, / and = complete on the next byte, others on their last.
//   s_tready is high while the queue has room for two results, so a stalled
//   receiver halts input after the queue fills; nothing is dropped.
//   Reset (rst_n low, asynchronous): queue emptied, line count 1, byte
//   position 0, lexer idle between tokens.
// ----------------------------------------------------------------------------
module c_subset_lexer
    import csl_pkg::*;
#(
    parameter int unsigned LINE_BITS     = DEF_LINE_BITS,
    parameter int unsigned POSITION_BITS = DEF_POSITION_BITS,
    parameter int unsigned LENGTH_BITS   = DEF_LENGTH_BITS,
    localparam int unsigned DATA_W       = KIND_W + ERR_W + LINE_BITS
                                           + POSITION_BITS + LENGTH_BITS,
    localparam int unsigned M_DATA_W     = ((DATA_W + 7) / 8) * 8
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [7:0]          s_tdata,   // [7:0] source_byte
    input  logic                s_tlast,   // end_of_input
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [M_DATA_W-1:0] m_tdata,   // token_kind, error_code, line_number,
                                           // lexeme_start, lexeme_length, zero pad
    output logic                m_tlast    // last_of_run
);

    localparam int unsigned ENT_W = DATA_W + 1;

    typedef logic [LINE_BITS-1:0]     line_t;
    typedef logic [POSITION_BITS-1:0] pos_t;
    typedef logic [LENGTH_BITS-1:0]   len_t;

    // Lexer state
    mode_t       mode_reg,  mode_next;
    logic [39:0] kw_reg,    kw_next;
    len_t        len_reg,   len_next;
    pos_t        start_reg, start_next;
    pos_t        pos_reg,   pos_next;
    line_t       line_reg,  line_next;
    line_t       tline_reg, tline_next;
    logic        star_reg,  star_next;

    // Result queue
    logic [ENT_W-1:0] q_reg [4];
    logic [1:0]       wr_reg, wr_next;
    logic [1:0]       rd_reg, rd_next;
    logic [2:0]       cnt_reg, cnt_next;

    logic        in_xfer, out_xfer;
    logic [7:0]  b;
    logic [7:0]  up;
    len_t        len_inc;
    logic        restart;
    logic [KIND_W:0] op;

    logic              p1_v, p2_v;
    logic [KIND_W-1:0] p1_kind, p2_kind;
    logic [ERR_W-1:0]  p1_err, p2_err;
    len_t              p1_len, p2_len;
    logic [DATA_W-1:0] p1_data, p2_data;

    assign in_xfer  = s_tvalid && s_tready;
    assign out_xfer = m_tvalid && m_tready;
    assign b        = s_tdata;
    assign up       = to_upper(b);
    assign len_inc  = (len_reg == '1) ? len_reg : len_reg + 1'b1;
    assign op       = op_kind(b);

    // Next lexer state and results for the byte on the slave side
    always_comb
    begin
        mode_next  = mode_reg;
        kw_next    = kw_reg;
        len_next   = len_reg;
        start_next = start_reg;
        tline_next = tline_reg;
        star_next  = star_reg;
        pos_next   = pos_reg + 1'b1;
        line_next  = ((b == CH_NL) && (line_reg != '1)) ? line_reg + 1'b1 : line_reg;
        restart    = 1'b0;
        p1_v       = 1'b0;
        p1_kind    = K_VOID;
        p1_err     = E_NONE;
        p1_len     = len_reg;
        p2_v       = 1'b0;
        p2_kind    = K_VOID;
        p2_err     = E_NONE;
        p2_len     = '0;

        if (s_tlast)
        begin
            // flush, then back to reset state
            case (mode_reg)
                M_IDENT:
                begin
                    p1_v    = 1'b1;
                    p1_kind = word_kind(kw_reg, len_reg <= LENGTH_BITS'(5));
                end
                M_NUMBER:
                begin
                    p1_v    = 1'b1;
                    p1_kind = K_INT;
                end
                M_SLASH:
                begin
                    p1_v    = 1'b1;
                    p1_kind = K_SLASH;
                end
                M_ASSIGN:
                begin
                    p1_v    = 1'b1;
                    p1_kind = K_ASSIGN;
                end
                M_COMMENT:
                begin
                    p1_v   = 1'b1;
                    p1_err = E_COMMENT;
                    p1_len = '0;
                end
                M_STRING, M_STRING_ESC:
                begin
                    p1_v   = 1'b1;
                    p1_err = E_STRING;
                    p1_len = '0;
                end
                M_CHAR_OPEN, M_CHAR_ESC, M_CHAR_CLOSE:
                begin
                    p1_v   = 1'b1;
                    p1_err = E_CHAR;
                    p1_len = '0;
                end
                default:
                begin
                end
            endcase
            mode_next  = M_IDLE;
            kw_next    = '0;
            len_next   = '0;
            start_next = '0;
            pos_next   = '0;
            line_next  = LINE_BITS'(1);
            tline_next = LINE_BITS'(1);
            star_next  = 1'b0;
        end
        else
        begin
            // continue the current token
            case (mode_reg)
                M_IDENT:
                begin
                    if (is_alpha(b) || is_digit(b) || (b == CH_UNDER))
                    begin
                        if (len_reg < LENGTH_BITS'(5))
                            kw_next = {kw_reg[31:0], up};
                        len_next = len_inc;
                    end
                    else
                    begin
                        p1_v    = 1'b1;
                        p1_kind = word_kind(kw_reg, len_reg <= LENGTH_BITS'(5));
                        restart = 1'b1;
                    end
                end
                M_NUMBER:
                begin
                    if (is_digit(b))
                        len_next = len_inc;
                    else
                    begin
                        p1_v    = 1'b1;
                        p1_kind = K_INT;
                        restart = 1'b1;
                    end
                end
                M_SLASH:
                begin
                    if (b == CH_STAR)
                    begin
                        star_next = 1'b0;
                        mode_next = M_COMMENT;
                    end
                    else
                    begin
                        p1_v    = 1'b1;
                        p1_kind = K_SLASH;
                        restart = 1'b1;
                    end
                end
                M_ASSIGN:
                begin
                    p1_v = 1'b1;
                    if (b == CH_EQ)
                    begin
                        p1_kind   = K_EQ;
                        p1_len    = LENGTH_BITS'(2);
                        len_next  = LENGTH_BITS'(2);
                        mode_next = M_IDLE;
                    end
                    else
                    begin
                        p1_kind = K_ASSIGN;
                        restart = 1'b1;
                    end
                end
                M_COMMENT:
                begin
                    if (star_reg && (b == CH_SLASH))
                    begin
                        star_next = 1'b0;
                        mode_next = M_IDLE;
                    end
                    else
                        star_next = (b == CH_STAR);
                end
                M_STRING, M_STRING_ESC:
                begin
                    if (b == CH_NL)
                    begin
                        p1_v      = 1'b1;
                        p1_err    = E_STRING;
                        p1_len    = '0;
                        mode_next = M_IDLE;
                    end
                    else if ((mode_reg == M_STRING) && (b == CH_DQ))
                    begin
                        p1_v      = 1'b1;
                        p1_kind   = K_STRING;
                        mode_next = M_IDLE;
                    end
                    else
                    begin
                        len_next  = len_inc;
                        mode_next = ((mode_reg == M_STRING) && (b == CH_BSL))
                                    ? M_STRING_ESC : M_STRING;
                    end
                end
                M_CHAR_OPEN:
                begin
                    if ((b == CH_SQ) || (b == CH_NL))
                    begin
                        p1_v      = 1'b1;
                        p1_err    = E_CHAR;
                        p1_len    = '0;
                        mode_next = M_IDLE;
                    end
                    else
                    begin
                        len_next  = LENGTH_BITS'(1);
                        mode_next = (b == CH_BSL) ? M_CHAR_ESC : M_CHAR_CLOSE;
                    end
                end
                M_CHAR_ESC:
                begin
                    if (b == CH_NL)
                    begin
                        p1_v      = 1'b1;
                        p1_err    = E_CHAR;
                        p1_len    = '0;
                        mode_next = M_IDLE;
                    end
                    else
                    begin
                        len_next  = LENGTH_BITS'(2);
                        mode_next = M_CHAR_CLOSE;
                    end
                end
                M_CHAR_CLOSE:
                begin
                    p1_v = 1'b1;
                    if (b == CH_SQ)
                    begin
                        p1_kind   = K_CHAR;
                        mode_next = M_IDLE;
                    end
                    else
                    begin
                        p1_err    = E_CHAR;
                        p1_len    = '0;
                        mode_next = (b == CH_NL) ? M_IDLE : M_CHAR_SKIP;
                    end
                end
                M_CHAR_SKIP:
                begin
                    if ((b == CH_NL) || (b == CH_SQ))
                        mode_next = M_IDLE;
                end
                M_SKIP_LINE:
                begin
                    if (b == CH_NL)
                        mode_next = M_IDLE;
                end
                default:
                    restart = 1'b1;
            endcase

            // start a new token with this byte
            if (restart)
            begin
                start_next = pos_reg;
                tline_next = line_reg;
                len_next   = LENGTH_BITS'(1);
                mode_next  = M_IDLE;
                if (is_space(b))
                begin
                end
                else if (is_alpha(b) || (b == CH_UNDER))
                begin
                    kw_next   = {32'd0, up};
                    mode_next = M_IDENT;
                end
                else if (is_digit(b))
                    mode_next = M_NUMBER;
                else if (b == CH_SLASH)
                    mode_next = M_SLASH;
                else if (b == CH_EQ)
                    mode_next = M_ASSIGN;
                else if ((b == CH_DQ) || (b == CH_SQ))
                begin
                    start_next = pos_reg + 1'b1;
                    len_next   = '0;
                    mode_next  = (b == CH_DQ) ? M_STRING : M_CHAR_OPEN;
                end
                else if (op[KIND_W])
                begin
                    p2_v    = 1'b1;
                    p2_kind = op[KIND_W-1:0];
                    p2_len  = LENGTH_BITS'(1);
                end
                else
                begin
                    p2_v      = 1'b1;
                    p2_err    = E_UNDEF;
                    mode_next = M_SKIP_LINE;
                end
            end
        end
    end

    // Pack results: the second one carries the start of the new token
    assign p1_data = {p1_len, start_reg, tline_reg, p1_err, p1_kind};
    assign p2_data = {p2_len, pos_reg, line_reg, p2_err, p2_kind};

    // Queue pointers and fill count
    always_comb
    begin
        wr_next  = wr_reg;
        rd_next  = rd_reg;
        cnt_next = cnt_reg;
        if (in_xfer)
        begin
            wr_next  = wr_reg + {1'b0, p1_v} + {1'b0, p2_v};
            cnt_next = cnt_reg + {2'b00, p1_v} + {2'b00, p2_v};
        end
        if (out_xfer)
        begin
            rd_next  = rd_reg + 1'b1;
            cnt_next = cnt_next - 1'b1;
        end
    end

    // Hold control and lexer state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= M_IDLE;
            kw_reg    <= '0;
            len_reg   <= '0;
            start_reg <= '0;
            pos_reg   <= '0;
            line_reg  <= LINE_BITS'(1);
            tline_reg <= LINE_BITS'(1);
            star_reg  <= 1'b0;
            wr_reg    <= '0;
            rd_reg    <= '0;
            cnt_reg   <= '0;
        end
        else
        begin
            if (in_xfer)
            begin
                mode_reg  <= mode_next;
                kw_reg    <= kw_next;
                len_reg   <= len_next;
                start_reg <= start_next;
                pos_reg   <= pos_next;
                line_reg  <= line_next;
                tline_reg <= tline_next;
                star_reg  <= star_next;
            end
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    // Write results into the queue
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            if (p1_v)
                q_reg[wr_reg] <= {!p2_v, p1_data};
            if (p2_v)
                q_reg[wr_reg + {1'b0, p1_v}] <= {1'b1, p2_data};
        end
    end

    assign s_tready = (cnt_reg <= 3'd2);
    assign m_tvalid = (cnt_reg != 3'd0);
    assign m_tdata  = M_DATA_W'(q_reg[rd_reg][DATA_W-1:0]);
    assign m_tlast  = q_reg[rd_reg][DATA_W];

`ifndef SYNTHESIS
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= 3'd4)
        else $error("result queue overflow");

    a_eoi_mode: assert property (@(posedge clk) disable iff (!rst_n)
        (in_xfer && s_tlast) |=> (mode_reg == M_IDLE))
        else $error("lexer not idle after end of input");

    a_eoi_counts: assert property (@(posedge clk) disable iff (!rst_n)
        (in_xfer && s_tlast) |=> ((pos_reg == '0) && (line_reg == LINE_BITS'(1))))
        else $error("position or line not restarted after end of input");
`endif

endmodule

[test/tb_c_subset_lexer.sv]
// ----------------------------------------------------------------------------
// tb_c_subset_lexer
// Self-checking bench for the C subset lexer. Source text goes in as a byte
// stream and every token or error coming out is compared, field by field,
// with a behavioral lexer kept in the scoreboard. The bench applies random
// stalls on both channels and covers each error case with directed text.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_c_subset_lexer;
    import csl_pkg::*;

    typedef struct packed {
        logic [4:0]  kind;
        logic [2:0]  err;
        logic [19:0] line;
        logic [31:0] start;
        logic [15:0] len;
        logic        last;
    } token_t;

    // Behavioral lexer and queue of expected tokens
    class token_scoreboard;
        token_t      expected_tokens[$];
        token_t      produced[$];
        int          mismatches;
        mode_t       mode;
        logic [39:0] letters;
        logic [15:0] tok_len;
        logic [31:0] tok_start;
        logic [31:0] pos;
        logic [19:0] line_cnt;
        logic [19:0] tok_line;
        logic        star;
        string       words[8];
        string       ops;

        function new();
            words = '{"VOID", "CHAR", "INT", "IF", "ELSE", "WHILE", "FOR", "MAIN"};
            ops = "+-*/><(){}[];,";
            mismatches = 0;
            clear();
        endfunction

        function void clear();
            mode = M_IDLE;
            letters = '0;
            tok_len = '0;
            tok_start = '0;
            pos = '0;
            line_cnt = 20'd1;
            tok_line = 20'd1;
            star = 1'b0;
        endfunction

        function void put(logic [4:0] k, logic [2:0] e, logic [15:0] l);
            token_t t;
            t.kind = k;
            t.err = e;
            t.line = tok_line;
            t.start = tok_start;
            t.len = l;
            t.last = 1'b0;
            if (produced.size() < 2)
                produced.push_back(t);
        endfunction

        function void fail_tok(logic [2:0] e);
            put(K_VOID, e, 16'd0);
            mode = M_IDLE;
        endfunction

        function void emit(logic [4:0] k);
            put(k, E_NONE, tok_len);
            mode = M_IDLE;
        endfunction

        function void grow();
            if (tok_len != 16'hFFFF)
                tok_len++;
        endfunction

        function bit letter_p(logic [7:0] b);
            return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z");
        endfunction

        function bit digit_p(logic [7:0] b);
            return b >= "0" && b <= "9";
        endfunction

        function void add_letter(logic [7:0] b);
            logic [7:0] u;
            u = (b >= "a" && b <= "z") ? b - 8'd32 : b;
            if (tok_len < 16'd5)
                letters = {letters[31:0], u};
            grow();
        endfunction

        function void emit_word();
            logic [4:0]  k;
            logic [39:0] p;
            k = K_IDENT;
            if (tok_len <= 16'd5)
            begin
                for (int w = 7; w >= 0; w--)
                begin
                    p = '0;
                    for (int i = 0; i < words[w].len(); i++)
                        p = {p[31:0], words[w][i]};
                    if (words[w].len() == tok_len && p == letters)
                        k = K_VOID + 5'(w);
                end
            end
            emit(k);
        endfunction

        function void start_byte(logic [7:0] b);
            tok_start = pos;
            tok_line = line_cnt;
            tok_len = 16'd1;
            mode = M_IDLE;
            if (b == 8'h20 || (b >= 8'h09 && b <= 8'h0D))
                return;
            if (letter_p(b) || b == "_")
            begin
                letters = '0;
                tok_len = '0;
                add_letter(b);
                mode = M_IDENT;
                return;
            end
            if (digit_p(b))
            begin
                mode = M_NUMBER;
                return;
            end
            if (b == "/")
            begin
                mode = M_SLASH;
                return;
            end
            if (b == "=")
            begin
                mode = M_ASSIGN;
                return;
            end
            if (b == CH_DQ || b == CH_SQ)
            begin
                tok_start = pos + 32'd1;
                tok_len = '0;
                mode = (b == CH_DQ) ? M_STRING : M_CHAR_OPEN;
                return;
            end
            for (int i = 0; i < ops.len(); i++)
            begin
                if (b == ops[i])
                begin
                    emit(K_PLUS + 5'(i));
                    return;
                end
            end
            fail_tok(E_UNDEF);
            mode = M_SKIP_LINE;
        endfunction

        function void consume(logic [7:0] b);
            case (mode)
                M_IDENT:
                    if (letter_p(b) || digit_p(b) || b == "_")
                        add_letter(b);
                    else
                    begin
                        emit_word();
                        start_byte(b);
                    end
                M_NUMBER:
                    if (digit_p(b))
                        grow();
                    else
                    begin
                        emit(K_INT);
                        start_byte(b);
                    end
                M_SLASH:
                    if (b == "*")
                    begin
                        star = 1'b0;
                        mode = M_COMMENT;
                    end
                    else
                    begin
                        emit(K_SLASH);
                        start_byte(b);
                    end
                M_ASSIGN:
                    if (b == "=")
                    begin
                        tok_len = 16'd2;
                        emit(K_EQ);
                    end
                    else
                    begin
                        emit(K_ASSIGN);
                        start_byte(b);
                    end
                M_COMMENT:
                    if (star && b == "/")
                    begin
                        star = 1'b0;
                        mode = M_IDLE;
                    end
                    else
                        star = (b == "*");
                M_STRING:
                    if (b == CH_NL)
                        fail_tok(E_STRING);
                    else if (b == CH_DQ)
                        emit(K_STRING);
                    else
                    begin
                        grow();
                        if (b == CH_BSL)
                            mode = M_STRING_ESC;
                    end
                M_STRING_ESC:
                    if (b == CH_NL)
                        fail_tok(E_STRING);
                    else
                    begin
                        grow();
                        mode = M_STRING;
                    end
                M_CHAR_OPEN:
                    if (b == CH_SQ || b == CH_NL)
                        fail_tok(E_CHAR);
                    else
                    begin
                        tok_len = 16'd1;
                        mode = (b == CH_BSL) ? M_CHAR_ESC : M_CHAR_CLOSE;
                    end
                M_CHAR_ESC:
                    if (b == CH_NL)
                        fail_tok(E_CHAR);
                    else
                    begin
                        tok_len = 16'd2;
                        mode = M_CHAR_CLOSE;
                    end
                M_CHAR_CLOSE:
                    if (b == CH_SQ)
                        emit(K_CHAR);
                    else
                    begin
                        fail_tok(E_CHAR);
                        mode = (b == CH_NL) ? M_IDLE : M_CHAR_SKIP;
                    end
                M_CHAR_SKIP:
                    if (b == CH_NL || b == CH_SQ)
                        mode = M_IDLE;
                M_SKIP_LINE:
                    if (b == CH_NL)
                        mode = M_IDLE;
                default:
                    start_byte(b);
            endcase
        endfunction

        function void flush_source();
            case (mode)
                M_IDENT:      emit_word();
                M_NUMBER:     emit(K_INT);
                M_SLASH:      emit(K_SLASH);
                M_ASSIGN:     emit(K_ASSIGN);
                M_COMMENT:    fail_tok(E_COMMENT);
                M_STRING, M_STRING_ESC: fail_tok(E_STRING);
                M_CHAR_OPEN, M_CHAR_ESC, M_CHAR_CLOSE: fail_tok(E_CHAR);
                default: ;
            endcase
        endfunction

        // Note one accepted source transfer
        function void note_input(logic [7:0] b, logic eoi);
            produced.delete();
            if (eoi)
            begin
                flush_source();
                clear();
            end
            else
            begin
                consume(b);
                if (b == CH_NL && line_cnt != 20'hFFFFF)
                    line_cnt++;
                pos++;
            end
            if (produced.size() > 0)
                produced[produced.size() - 1].last = 1'b1;
            foreach (produced[i])
                expected_tokens.push_back(produced[i]);
        endfunction

        // Check one accepted result transfer
        function void check_result(logic [79:0] d, logic tl);
            token_t got, exp;
            got = {d[4:0], d[7:5], d[27:8], d[59:28], d[75:60], tl};
            if (expected_tokens.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: unexpected result %h", $realtime, got);
                return;
            end
            exp = expected_tokens.pop_front();
            if (got.kind !== exp.kind || got.err !== exp.err || got.line !== exp.line ||
                got.start !== exp.start || got.len !== exp.len ||
                got.last !== exp.last || d[79:76] !== 4'd0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: exp %0d/%0d/%0d/%0d/%0d/%0d got %0d/%0d/%0d/%0d/%0d/%0d",
                             $realtime, exp.kind, exp.err, exp.line, exp.start, exp.len,
                             exp.last, got.kind, got.err, got.line, got.start, got.len,
                             got.last);
            end
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = '0;
    logic        s_tlast = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [79:0] m_tdata;
    logic        m_tlast;

    token_scoreboard sb = new();
    bit  stalls_on = 1'b1;
    int  rx_stall = 0;
    int  quiet_cycles = 0;

    c_subset_lexer dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    always #5 clk = ~clk;

    // Receive tokens with random stall bursts
    always @(posedge clk)
    begin
        if (m_tvalid && m_tready)
            sb.check_result(m_tdata, m_tlast);
        if (!rst_n)
            m_tready <= 1'b0;
        else if (rx_stall > 0)
        begin
            rx_stall--;
            m_tready <= 1'b0;
        end
        else if (stalls_on && $urandom_range(0, 5) == 0)
        begin
            rx_stall = $urandom_range(0, 3);
            m_tready <= 1'b0;
        end
        else
            m_tready <= 1'b1;
    end

    // Watchdog on cycles with no transfer on either channel
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles = 0;
        else if (rst_n)
            quiet_cycles++;
        if (quiet_cycles >= 5000)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // Drive one source transfer, with an optional idle burst first
    task automatic send_byte(logic [7:0] b, logic eoi);
        if (stalls_on && $urandom_range(0, 7) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= b;
        s_tlast <= eoi;
        do
            @(posedge clk);
        while (!s_tready);
        sb.note_input(b, eoi);
    endtask

    task automatic send_text(string s);
        for (int i = 0; i < s.len(); i++)
            send_byte(s[i], 1'b0);
    endtask

    task automatic send_end();
        send_byte(8'($urandom_range(0, 255)), 1'b1);
    endtask

    // Random case for a keyword or a plain letter run
    task automatic send_word(string w);
        for (int i = 0; i < w.len(); i++)
            send_byte($urandom_range(0, 1) ? w[i] : w[i] + 8'd32, 1'b0);
    endtask

    // One random fragment of C-like text
    task automatic send_fragment();
        string words[8];
        string ops;
        int    n;
        words = '{"VOID", "CHAR", "INT", "IF", "ELSE", "WHILE", "FOR", "MAIN"};
        ops = "+-*/><(){}[];,=";
        case ($urandom_range(0, 13))
            0, 1: send_word(words[$urandom_range(0, 7)]);
            2:
            begin
                send_byte($urandom_range(0, 1) ? "_" : 8'("a" + $urandom_range(0, 25)),
                          1'b0);
                n = $urandom_range(0, 7);
                repeat (n)
                    send_byte($urandom_range(0, 2) == 0 ? 8'("0" + $urandom_range(0, 9))
                              : 8'("A" + $urandom_range(0, 25)), 1'b0);
            end
            3: repeat ($urandom_range(1, 5)) send_byte(8'("0" + $urandom_range(0, 9)), 1'b0);
            4, 5: send_byte(ops[$urandom_range(0, ops.len() - 1)], 1'b0);
            6: send_text("==");
            7:
            begin
                send_byte(CH_DQ, 1'b0);
                repeat ($urandom_range(0, 5))
                    send_byte($urandom_range(0, 3) == 0 ? CH_BSL
                              : 8'("a" + $urandom_range(0, 25)), 1'b0);
                if ($urandom_range(0, 5) == 0)
                    send_byte(CH_NL, 1'b0);
                else
                    send_byte(CH_DQ, 1'b0);
            end
            8:
            begin
                send_byte(CH_SQ, 1'b0);
                case ($urandom_range(0, 5))
                    0: send_byte(CH_SQ, 1'b0);
                    1: send_text("\\n'");
                    2: send_text("ab'");
                    3: send_byte(CH_NL, 1'b0);
                    default:
                    begin
                        send_byte(8'("0" + $urandom_range(0, 74)), 1'b0);
                        send_byte(CH_SQ, 1'b0);
                    end
                endcase
            end
            9: send_text($urandom_range(0, 3) == 0 ? "/* a * b **/" : "/*x*/");
            10: send_byte($urandom_range(0, 1) ? CH_NL : 8'(8'h09 + $urandom_range(0, 4)),
                          1'b0);
            11, 12: send_byte(" ", 1'b0);
            default:
                if ($urandom_range(0, 4) == 0)
                    send_end();
                else
                    send_byte(8'($urandom_range(0, 255)), 1'b0);
        endcase
    endtask

    initial
    begin
        int sent;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: keywords, operators, literals and each error case
        send_text("void Char iNt IF else While fOR main whiles x_9 123 = == /3");
        send_text("+-*/><(){}[];, \"a\\\"b\" '\\n' 'c' '' 'xy' $junk\n");
        send_byte(8'h00, 1'b0);
        send_byte(CH_NL, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_text("\n\"open\nab");
        send_end();
        send_text("/* open *");
        send_end();
        send_text("\"s");
        send_end();
        send_text("'\\");
        send_end();
        send_text("'\n'\\\n");
        send_byte(8'hA5, 1'b1);

        // Hold off until every token has come out
        s_tvalid <= 1'b0;
        while (sb.expected_tokens.size() != 0)
            @(posedge clk);

        // Random text, the last part with no stalls
        sent = 0;
        while (sent < 100)
        begin
            if (sent > 80)
                stalls_on = 1'b0;
            send_fragment();
            sent++;
        end
        send_end();
        s_tvalid <= 1'b0;

        while (sb.expected_tokens.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        if (sb.mismatches == 0 && sb.expected_tokens.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
